### sv/aes_pkg.sv
`default_nettype none
package aes_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [127:0] blk_t;

  localparam int NUM_ROUNDS = 10;
  localparam int KEY_WORDS = 44;

  // Register indexes of the configuration port.
  localparam logic REG_KEY_HIGH = 1'b0;
  localparam logic REG_KEY_LOW  = 1'b1;

  // Forward S-box.
  localparam byte_t FWD_SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  // Inverse S-box.
  localparam byte_t INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

  // Multiply by x in GF(2^8), polynomial 0x11b.
  function automatic byte_t xtime(input byte_t a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Forward MixColumns on one column (byte 0 in bits 31:24).
  function automatic logic [31:0] mix_fwd(input logic [31:0] c);
    byte_t a0, a1, a2, a3;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    mix_fwd = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
               a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
               a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
               xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
  endfunction

  // Inverse MixColumns: pre-multiply by {05,00,04,00} then forward mix.
  function automatic logic [31:0] mix_inv(input logic [31:0] c);
    byte_t a0, a1, a2, a3, u, v;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    u = xtime(xtime(a0 ^ a2));
    v = xtime(xtime(a1 ^ a3));
    mix_inv = mix_fwd({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
  endfunction

endpackage
`default_nettype wire

### sv/aes_stream_if.sv
`default_nettype none
interface aes_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [63:0] block_high;
  logic [63:0] block_low;
  modport source (output valid, func, block_high, block_low, input ready);
  modport sink (input valid, func, block_high, block_low, output ready);
endinterface

interface aes_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  modport source (output valid, result_high, result_low, input ready);
  modport sink (input valid, result_high, result_low, output ready);
endinterface
`default_nettype wire

### sv/aes_ram.sv
`default_nettype none
module aes_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 44
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### sv/aes_round.sv
`default_nettype none
module aes_round (
  input  wire logic         dec,
  input  wire logic         last,
  input  wire aes_pkg::blk_t st,
  input  wire aes_pkg::blk_t rkey,
  output aes_pkg::blk_t     nxt
);
  aes_pkg::blk_t sr, sb, ak, mx;

  // One round on the whole state. Byte k is at bits 127-8k; row k%4, column k/4.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[127-8*(4*c+r) -: 8] = dec ? st[127-8*(4*((c-r+4)%4)+r) -: 8]
                                     : st[127-8*(4*((c+r)%4)+r) -: 8];
      end
    end
    for (int k = 0; k < 16; k++) begin
      sb[127-8*k -: 8] = dec ? aes_pkg::INV_SBOX[sr[127-8*k -: 8]]
                             : aes_pkg::FWD_SBOX[sr[127-8*k -: 8]];
    end
    // Encrypt: mix then add key. Decrypt: add key then inverse mix. The last round skips the mix.
    ak = dec ? (sb ^ rkey) : sb;
    for (int c = 0; c < 4; c++) begin
      mx[127-32*c -: 32] = dec ? aes_pkg::mix_inv(ak[127-32*c -: 32])
                               : aes_pkg::mix_fwd(ak[127-32*c -: 32]);
    end
    if (dec) begin
      nxt = last ? ak : mx;
    end else begin
      nxt = (last ? sb : mx) ^ rkey;
    end
  end
endmodule
`default_nettype wire

### sv/aes128_block_cipher.sv
`default_nettype none
// AES-128 encrypt/decrypt of one 128-bit block per request (func 0 encrypts,
// 1 decrypts; byte 0 in the top bits). The key sits in two 64-bit registers
// at byte addresses 0 (key_high) and 8 (key_low). After reset or a key
// write, the next request first expands the 44 round-key words into a small
// RAM, one word a cycle. The request then passes the load state, after which
// the initial key add is applied and one shared round unit runs the ten
// rounds; each of those eleven steps waits on four reads through the single
// read port of the round-key RAM. The result waits until taken and the block
// is ready again in the cycle after it leaves. The block takes no request
// while one is in flight or its result waits.
module aes128_block_cipher (
  input  wire logic        clk,
  input  wire logic        rst_n,
  aes_in_if.sink           in_ch,
  aes_out_if.source        out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic      [63:0] cfg_prdata,
  output logic             cfg_pready
);
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXP   = 5'b00010,
    S_LOAD  = 5'b00100,
    S_ROUND = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  // When a round key is applied, rnd_r already points at the next key to read,
  // so the last round is applied one step past round ten (encrypt) or one step
  // below round zero, wrapped (decrypt).
  localparam logic [3:0] ENC_END = 4'(aes_pkg::NUM_ROUNDS + 1);
  localparam logic [3:0] DEC_END = 4'hf;

  state_t state_r, state_nxt;
  logic [63:0] key_hi_r, key_lo_r;
  logic        keys_ok_r;
  logic        dec_r;
  aes_pkg::blk_t st_r;
  logic [95:0] rk_r;        // first three words of the round key
  logic [5:0]  widx_r;      // key-schedule word being written
  logic [1:0]  sub_r;       // word within a round key
  logic [3:0]  rnd_r;       // round key being read
  logic        first_r;     // initial key add pending
  logic        rd_vld_r;
  logic [31:0] w1_r, w2_r, w3_r, w4_r; // last four schedule words
  logic [7:0]  rcon_r;
  logic        wr_en;
  logic [31:0] wr_word, tmp, rd_data;
  logic [5:0]  rd_addr;
  aes_pkg::blk_t rnd_out, rk_full;
  logic        last_rnd;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[3] == aes_pkg::REG_KEY_LOW) ? key_lo_r : key_hi_r;

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_DONE);
  assign out_ch.result_high = st_r[127:64];
  assign out_ch.result_low  = st_r[63:0];

  // Next schedule word from the previous four; the first four words are the key.
  always_comb begin
    tmp = w1_r;
    if (widx_r[1:0] == 2'd0) begin
      tmp = {aes_pkg::FWD_SBOX[w1_r[23:16]], aes_pkg::FWD_SBOX[w1_r[15:8]],
             aes_pkg::FWD_SBOX[w1_r[7:0]], aes_pkg::FWD_SBOX[w1_r[31:24]]}
            ^ {rcon_r, 24'h0};
    end
    if (widx_r < 6'd4) begin
      wr_word = w4_r;
    end else begin
      wr_word = w4_r ^ tmp;
    end
  end
  assign wr_en = (state_r == S_EXP);

  // Read address: the key word for the round unit.
  assign rd_addr = 6'({rnd_r, sub_r});

  aes_ram #(.WIDTH(32), .DEPTH(aes_pkg::KEY_WORDS)) u_keys (
    .clk(clk), .we(wr_en), .waddr(widx_r), .wdata(wr_word),
    .raddr(rd_addr), .rdata(rd_data)
  );

  // The round key is complete when its fourth word returns from the RAM.
  assign rk_full = {rk_r, rd_data};
  assign last_rnd = dec_r ? (rnd_r == DEC_END) : (rnd_r == ENC_END);

  aes_round u_round (
    .dec(dec_r), .last(last_rnd),
    .st(st_r), .rkey(rk_full), .nxt(rnd_out)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_ch.valid) state_nxt = keys_ok_r ? S_LOAD : S_EXP;
      S_EXP:   if (widx_r == 6'(aes_pkg::KEY_WORDS - 1)) state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_ROUND;
      S_ROUND: if (rd_vld_r && sub_r == 2'd0 && !first_r && last_rnd)
                 state_nxt = S_DONE;
      S_DONE:  if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      key_hi_r  <= '0;
      key_lo_r  <= '0;
      keys_ok_r <= 1'b0;
      rd_vld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // Key registers; any key write forces a new expansion.
      if (cfg_wr && cfg_paddr[2:0] == 3'd0 && cfg_paddr[3] == aes_pkg::REG_KEY_HIGH) begin
        key_hi_r  <= cfg_pwdata;
        keys_ok_r <= 1'b0;
      end else if (cfg_wr && cfg_paddr[2:0] == 3'd0) begin
        key_lo_r  <= cfg_pwdata;
        keys_ok_r <= 1'b0;
      end else if (state_r == S_EXP && state_nxt == S_LOAD) begin
        keys_ok_r <= 1'b1;
      end
      // A read issued in the previous round-step cycle returns now.
      rd_vld_r <= (state_r == S_LOAD) || (state_r == S_ROUND && state_nxt == S_ROUND);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          dec_r   <= in_ch.func;
          // Seed the schedule with the four key words; word 0 is written first.
          w4_r    <= key_hi_r[63:32];
          w3_r    <= key_hi_r[31:0];
          w2_r    <= key_lo_r[63:32];
          w1_r    <= key_lo_r[31:0];
          widx_r  <= 6'd0;
          rcon_r  <= 8'h01;
        end
      end
      S_EXP: begin
        // Words 0..3 rotate through unchanged; from 4 on they are derived.
        w4_r <= w3_r; w3_r <= w2_r; w2_r <= w1_r; w1_r <= wr_word;
        if (widx_r >= 6'd4 && widx_r[1:0] == 2'd0) rcon_r <= aes_pkg::xtime(rcon_r);
        widx_r <= widx_r + 6'd1;
      end
      default: ;
    endcase
  end

  // Round key assembly and state updates.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      sub_r   <= 2'd0;
      first_r <= 1'b1;
      rnd_r   <= in_ch.func ? 4'(aes_pkg::NUM_ROUNDS) : 4'd0;
      if (in_ch.valid) begin
        st_r <= {in_ch.block_high, in_ch.block_low};
      end
    end else if (state_r == S_LOAD || (state_r == S_ROUND && state_nxt == S_ROUND)) begin
      if (rd_vld_r) begin
        rk_r <= {rk_r[63:0], rd_data};
      end
      if (rd_vld_r && sub_r == 2'd0) begin
        // Full round key held: apply it.
        if (first_r) begin
          st_r    <= st_r ^ rk_full;
          first_r <= 1'b0;
        end else begin
          st_r <= rnd_out;
        end
      end
      sub_r <= sub_r + 2'd1;
      if (sub_r == 2'd3) begin
        rnd_r <= dec_r ? rnd_r - 4'd1 : rnd_r + 4'd1;
      end
    end else if (state_r == S_ROUND) begin
      st_r <= rnd_out;
    end
  end
endmodule
`default_nettype wire

### sv/aes128_block_cipher_chk.sv
`default_nettype none
module aes128_block_cipher_chk (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready
);
  // Never takes a request while a result is shown.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");
  // A taken request closes the input right after acceptance.
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("ready after accept");
  // No result right after acceptance.
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid) else $error("early result");
  // A held result stays until taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule

bind aes128_block_cipher aes128_block_cipher_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready)
);
`default_nettype wire
